// ----- sv/assert_macros.svh -----
// Assertion macros for the port-level checker of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed: same-cycle implication.");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed: next-cycle implication.");

`endif

// ----- sv/rspd_pkg.sv -----
// Package with the shared types, register codes and pixel functions of the decoder.
`default_nettype none
package rspd_pkg;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned IMG_LEN_W  = 15;

   typedef enum logic [1:0] {
      CSR_PAL_OFFSET   = 2'd0,
      CSR_SKIP_ZERO    = 2'd1,
      CSR_IMAGE_LENGTH = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_HEADER  = 2'd0,
      ST_REPEAT  = 2'd1,
      ST_LITERAL = 2'd2,
      ST_EMIT    = 2'd3
   } state_type;

   typedef struct packed {
      logic [7:0]           pal_offset;
      logic                 skip_zero;
      logic [IMG_LEN_W-1:0] image_length;
   } cfg_type;

   typedef struct packed {
      logic load_header;
      logic load_repeat;
      logic load_literal;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hdr_repeat;
      logic out_free;
      logic lit_to_header;
      logic emit_last;
   } ctrl_sts_type;

   function automatic logic [7:0] pixel_value(input logic [7:0] raw, input logic [7:0] offset);
      pixel_value = raw + offset;
   endfunction

   function automatic logic pixel_write(input logic [7:0] raw, input logic skip);
      pixel_write = !(skip && (raw == 8'd0));
   endfunction

endpackage
`default_nettype wire

// ----- sv/rspd_csr.sv -----
// Configuration register file with its APB-style access port.
`default_nettype none
module rspd_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [rspd_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready,
   output rspd_pkg::cfg_type                    cfg
);
   import rspd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index  = csr_index_type'(paddr[3:2]);
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CSR_PAL_OFFSET:   cfg_in.pal_offset   = pwdata[7:0];
            CSR_SKIP_ZERO:    cfg_in.skip_zero    = pwdata[0];
            CSR_IMAGE_LENGTH: cfg_in.image_length = pwdata[IMG_LEN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_PAL_OFFSET:   prdata = {24'd0, cfg_ff.pal_offset};
         CSR_SKIP_ZERO:    prdata = {31'd0, cfg_ff.skip_zero};
         CSR_IMAGE_LENGTH: prdata = {{(32 - IMG_LEN_W){1'b0}}, cfg_ff.image_length};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pal_offset   <= 8'd0;
         cfg_ff.skip_zero    <= 1'b1;
         cfg_ff.image_length <= IMG_LEN_W'(256);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/rspd_ctrl.sv -----
// Controller state machine that sequences header, literal and repeat bytes.
`default_nettype none
module rspd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire rspd_pkg::ctrl_sts_type sts,
   output rspd_pkg::ctrl_cmd_type      cmd
);
   import rspd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_HEADER: begin
            if (req_valid) begin
               state_in = sts.hdr_repeat ? ST_REPEAT : ST_LITERAL;
            end
         end
         ST_LITERAL: begin
            if (req_valid && sts.out_free && sts.lit_to_header) begin
               state_in = ST_HEADER;
            end
         end
         ST_REPEAT: begin
            if (req_valid) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free && sts.emit_last) begin
               state_in = ST_HEADER;
            end
         end
         default: state_in = ST_HEADER;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_HEADER: begin
            req_stall       = 1'b0;
            cmd.load_header = req_valid;
         end
         ST_LITERAL: begin
            req_stall        = !sts.out_free;
            cmd.load_literal = req_valid && sts.out_free;
         end
         ST_REPEAT: begin
            req_stall       = 1'b0;
            cmd.load_repeat = req_valid;
         end
         ST_EMIT: begin
            cmd.emit = sts.out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HEADER;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/rspd_dp.sv -----
// Datapath with the run counters, pixel count, repeat emitter and result register.
`default_nettype none
module rspd_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rspd_pkg::cfg_type      cfg,
   input  wire rspd_pkg::ctrl_cmd_type cmd,
   output rspd_pkg::ctrl_sts_type      sts,
   input  wire logic [7:0]             req_code_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_pixel_first,
   output logic [7:0]                  rsp_pixel_second,
   output logic [1:0]                  rsp_pixel_count,
   output logic                        rsp_write_first,
   output logic                        rsp_write_second,
   output logic                        rsp_run_last,
   output logic                        rsp_image_done
);
   import rspd_pkg::*;

   logic [IMG_LEN_W-1:0] pixels_done_ff, pixels_done_in;
   logic [7:0]           run_cnt_ff, run_cnt_in;
   logic [7:0]           emit_left_ff, emit_left_in;
   logic                 emit_done_ff, emit_done_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           pix_ff, pix_in;
   logic                 wr_ff, wr_in;
   logic                 pair_ff, pair_in;
   logic                 last_ff, last_in;
   logic                 done_ff, done_in;

   logic [IMG_LEN_W-1:0] len;
   logic [IMG_LEN_W-1:0] left;
   logic [7:0]           rep_n;
   logic                 rep_done;
   logic                 lit_done;
   logic                 emit_pair;
   logic [7:0]           raw;

   assign len       = (cfg.image_length == '0) ? IMG_LEN_W'(1) : cfg.image_length;
   assign left      = (pixels_done_ff < len) ? (len - pixels_done_ff) : IMG_LEN_W'(1);
   assign rep_n     = (run_cnt_ff == 8'd0) ? 8'd1 : run_cnt_ff;
   assign rep_done  = {{(IMG_LEN_W - 8){1'b0}}, rep_n} >= left;
   assign lit_done  = ({1'b0, pixels_done_ff} + (IMG_LEN_W + 1)'(1)) >= {1'b0, len};
   assign emit_pair = |emit_left_ff[7:1];
   assign raw       = cmd.emit ? byte_ff : req_code_byte;

   assign sts.hdr_repeat    = req_code_byte[7];
   assign sts.out_free      = !rsp_valid_ff || !rsp_stall;
   assign sts.lit_to_header = lit_done || (run_cnt_ff == 8'd1);
   assign sts.emit_last     = emit_left_ff <= 8'd2;

   always_comb begin
      pixels_done_in = pixels_done_ff;
      run_cnt_in     = run_cnt_ff;
      emit_left_in   = emit_left_ff;
      emit_done_in   = emit_done_ff;
      byte_in        = byte_ff;
      pix_in         = pix_ff;
      wr_in          = wr_ff;
      pair_in        = pair_ff;
      last_in        = last_ff;
      done_in        = done_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      if (cmd.load_header) begin
         run_cnt_in = {1'b0, req_code_byte[6:0]} + 8'd1;
      end

      if (cmd.load_repeat) begin
         byte_in      = req_code_byte;
         emit_done_in = rep_done;
         emit_left_in = rep_done ? left[7:0] : rep_n;
         run_cnt_in   = 8'd0;
         pixels_done_in = rep_done ? '0
                                   : pixels_done_ff + {{(IMG_LEN_W - 8){1'b0}}, run_cnt_ff};
      end

      if (cmd.load_literal) begin
         pixels_done_in = lit_done ? '0 : pixels_done_ff + IMG_LEN_W'(1);
         run_cnt_in     = lit_done ? 8'd0 : run_cnt_ff - 8'd1;
         pair_in        = 1'b0;
         last_in        = 1'b1;
         done_in        = lit_done;
      end

      if (cmd.emit) begin
         emit_left_in = emit_left_ff - (emit_pair ? 8'd2 : 8'd1);
         pair_in      = emit_pair;
         last_in      = sts.emit_last;
         done_in      = emit_done_ff && sts.emit_last;
      end

      if (cmd.load_literal || cmd.emit) begin
         pix_in       = pixel_value(raw, cfg.pal_offset);
         wr_in        = pixel_write(raw, cfg.skip_zero);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixels_done_ff <= '0;
         run_cnt_ff     <= 8'd0;
         emit_left_ff   <= 8'd0;
         emit_done_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pixels_done_ff <= pixels_done_in;
         run_cnt_ff     <= run_cnt_in;
         emit_left_ff   <= emit_left_in;
         emit_done_ff   <= emit_done_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      pix_ff  <= pix_in;
      wr_ff   <= wr_in;
      pair_ff <= pair_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_first  = pix_ff;
   assign rsp_pixel_second = pair_ff ? pix_ff : 8'd0;
   assign rsp_pixel_count  = pair_ff ? 2'd2 : 2'd1;
   assign rsp_write_first  = wr_ff;
   assign rsp_write_second = pair_ff && wr_ff;
   assign rsp_run_last     = last_ff;
   assign rsp_image_done   = done_ff;

endmodule
`default_nettype wire

// ----- sv/rle_sprite_pixel_decoder.sv -----
// A literal byte's result is shown in the cycle after its transfer is accepted.
// A repeat data byte is registered first; its results come from the emit state.
// Header bytes are taken without a stall, literal bytes whenever the result
// register is free; a repeat byte holds off input until the two-pixel repeat emitter is done.
// Reset is synchronous and active high; it restores the register defaults and
// returns the decoder to expecting a header byte with no pixels counted.
`default_nettype none
module rle_sprite_pixel_decoder (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [7:0]                      req_code_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [7:0]                           rsp_pixel_first,
   output logic [7:0]                           rsp_pixel_second,
   output logic [1:0]                           rsp_pixel_count,
   output logic                                 rsp_write_first,
   output logic                                 rsp_write_second,
   output logic                                 rsp_run_last,
   output logic                                 rsp_image_done,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [rspd_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import rspd_pkg::*;

   cfg_type      cfg;
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   rspd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rspd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rspd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .sts              (sts),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_first  (rsp_pixel_first),
      .rsp_pixel_second (rsp_pixel_second),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_write_first  (rsp_write_first),
      .rsp_write_second (rsp_write_second),
      .rsp_run_last     (rsp_run_last),
      .rsp_image_done   (rsp_image_done)
   );

endmodule
`default_nettype wire

// ----- sv/rspd_checker.sv -----
// Port-level checker for the decoder and the bind that attaches it.
`default_nettype none
`include "assert_macros.svh"
module rspd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_pixel_first,
   input wire logic [7:0] rsp_pixel_second,
   input wire logic [1:0] rsp_pixel_count,
   input wire logic       rsp_write_first,
   input wire logic       rsp_write_second,
   input wire logic       rsp_run_last,
   input wire logic       rsp_image_done
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pixel_first) && $stable(rsp_pixel_count) && $stable(rsp_run_last))

   `ASSERT_IMPLIES(a_single_is_last, clock, reset, rsp_valid && (rsp_pixel_count == 2'd1), (rsp_pixel_second == 8'd0) && !rsp_write_second && rsp_run_last)

   `ASSERT_IMPLIES(a_pair_matches, clock, reset, rsp_valid && (rsp_pixel_count == 2'd2), (rsp_pixel_second == rsp_pixel_first) && (rsp_write_second == rsp_write_first))

   `ASSERT_IMPLIES(a_done_is_last, clock, reset, rsp_valid && rsp_image_done, rsp_run_last)

endmodule

bind rle_sprite_pixel_decoder rspd_checker u_rspd_checker (.*);
`default_nettype wire

// ----- verif/pixel_group_checker.sv -----
`timescale 1ns / 100ps
// Checker that follows the decoder's transfers, predicts every pixel group and compares them.
module pixel_group_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire logic [7:0]                      req_code_byte,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic [7:0]                      rsp_pixel_first,
   input  wire logic [7:0]                      rsp_pixel_second,
   input  wire logic [1:0]                      rsp_pixel_count,
   input  wire logic                            rsp_write_first,
   input  wire logic                            rsp_write_second,
   input  wire logic                            rsp_run_last,
   input  wire logic                            rsp_image_done,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic                            pready,
   input  wire logic [rspd_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output int                                   mismatches,
   output int                                   groups_due
);
   import rspd_pkg::*;

   typedef struct packed {
      logic [7:0] pixel_first;
      logic [7:0] pixel_second;
      logic [1:0] pixel_count;
      logic       write_first;
      logic       write_second;
      logic       run_last;
      logic       image_done;
   } pixel_group_type;

   pixel_group_type pixel_groups_due[$];

   cfg_type     cfg;
   state_type   dec_phase;
   logic [7:0]  lits_left;
   logic [7:0]  run_len;
   logic [14:0] pix_done;

   task automatic report(input string msg);
      if (mismatches < 40) begin
         $display("%0t: mismatch: %s", $realtime, msg);
      end
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) begin
         report($sformatf("%s is %0h, should be %0h", name, got, want));
      end
   endtask

   task automatic push_group(input logic [7:0] raw, input int cnt, input logic last,
                             input logic done);
      pixel_group_type g;
      logic [7:0]      pix;
      logic            wr;
      pix = raw + cfg.pal_offset;
      wr = !(cfg.skip_zero && raw == 8'd0);
      g.pixel_first = pix;
      g.pixel_second = (cnt == 2) ? pix : 8'd0;
      g.pixel_count = (cnt == 2) ? 2'd2 : 2'd1;
      g.write_first = wr;
      g.write_second = (cnt == 2) ? wr : 1'b0;
      g.run_last = last;
      g.image_done = done;
      pixel_groups_due.push_back(g);
   endtask

   task automatic clear_image();
      pix_done = '0;
      dec_phase = ST_HEADER;
      lits_left = '0;
      run_len = '0;
   endtask

   task automatic decode_byte(input logic [7:0] b);
      int   len;
      int   left;
      int   n;
      int   c;
      logic done;
      len = (cfg.image_length == 0) ? 1 : cfg.image_length;
      case (dec_phase)
         ST_REPEAT: begin
            left = (pix_done < len) ? len - pix_done : 1;
            n = (run_len == 0) ? 1 : run_len;
            done = 1'b0;
            if (n >= left) begin
               n = left;
               done = 1'b1;
            end
            while (n > 0) begin
               c = (n >= 2) ? 2 : 1;
               n -= c;
               push_group(b, c, n == 0, done && n == 0);
            end
            if (done) begin
               clear_image();
            end else begin
               pix_done = pix_done + run_len;
               dec_phase = ST_HEADER;
               run_len = '0;
            end
         end
         ST_LITERAL: begin
            done = (pix_done + 1 >= len);
            push_group(b, 1, 1'b1, done);
            if (done) begin
               clear_image();
            end else begin
               pix_done = pix_done + 15'd1;
               lits_left = lits_left - 8'd1;
               if (lits_left == 0) begin
                  dec_phase = ST_HEADER;
               end
            end
         end
         default: begin
            if (b[7]) begin
               run_len = {1'b0, b[6:0]} + 8'd1;
               dec_phase = ST_REPEAT;
            end else begin
               lits_left = {1'b0, b[6:0]} + 8'd1;
               dec_phase = ST_LITERAL;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      pixel_group_type want;
      if (reset) begin
         cfg.pal_offset = 8'd0;
         cfg.skip_zero = 1'b1;
         cfg.image_length = 15'd256;
         clear_image();
         pixel_groups_due.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pixel_groups_due.size() == 0) begin
               report("pixel group transfer with none due");
            end else begin
               want = pixel_groups_due.pop_front();
               check_field("pixel_first", rsp_pixel_first, want.pixel_first);
               check_field("pixel_second", rsp_pixel_second, want.pixel_second);
               check_field("pixel_count", rsp_pixel_count, want.pixel_count);
               check_field("write_first", rsp_write_first, want.write_first);
               check_field("write_second", rsp_write_second, want.write_second);
               check_field("run_last", rsp_run_last, want.run_last);
               check_field("image_done", rsp_image_done, want.image_done);
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_code_byte);
         end
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[3:2]))
               CSR_PAL_OFFSET:   cfg.pal_offset = pwdata[7:0];
               CSR_SKIP_ZERO:    cfg.skip_zero = pwdata[0];
               CSR_IMAGE_LENGTH: cfg.image_length = pwdata[IMG_LEN_W-1:0];
               default: ;
            endcase
         end
      end
      groups_due <= pixel_groups_due.size();
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Top of the sprite decoder testbench: clock, reset, byte stream, register writes and verdict.
module testbench;
   import rspd_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_code_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_pixel_first;
   logic [7:0]  rsp_pixel_second;
   logic [1:0]  rsp_pixel_count;
   logic        rsp_write_first;
   logic        rsp_write_second;
   logic        rsp_run_last;
   logic        rsp_image_done;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   logic        calm = 1'b0;
   logic        hold_go = 1'b0;
   logic        hold_spent = 1'b0;
   int          hold_cycles = 0;
   int          quiet_cycles = 0;
   int          sent = 0;
   int          mismatches;
   int          groups_due;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rle_sprite_pixel_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_first  (rsp_pixel_first),
      .rsp_pixel_second (rsp_pixel_second),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_write_first  (rsp_write_first),
      .rsp_write_second (rsp_write_second),
      .rsp_run_last     (rsp_run_last),
      .rsp_image_done   (rsp_image_done),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   pixel_group_checker pixel_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_first  (rsp_pixel_first),
      .rsp_pixel_second (rsp_pixel_second),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_write_first  (rsp_write_first),
      .rsp_write_second (rsp_write_second),
      .rsp_run_last     (rsp_run_last),
      .rsp_image_done   (rsp_image_done),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .pready           (pready),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .mismatches       (mismatches),
      .groups_due       (groups_due)
   );

   // The receiver stalls at random, except in a calm phase and one long hold-off that fills the decoder.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_go && !hold_spent) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles == HOLD_CYCLES - 1) begin
            hold_spent <= 1'b1;
         end
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 10);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] pixel_byte();
      return ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(255));
   endfunction

   function automatic logic [6:0] run_bits();
      return ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(7));
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_code_byte <= b;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (groups_due != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int         i;
      int         quota;
      int         phase_no;
      logic [6:0] n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: zero pixels skipped, no offset, 256-pixel images.
      send_byte(8'h80);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h02);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(8'h01);
      send_byte(8'h81);
      send_byte(8'h55);
      // This run crosses the end of the image and is cut short.
      send_byte(8'hFF);
      send_byte(8'hAA);
      settle();

      write_reg(CSR_PAL_OFFSET, 32'hFF);
      write_reg(CSR_SKIP_ZERO, 32'h0);
      write_reg(CSR_IMAGE_LENGTH, 32'd3);
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      send_byte(8'h7F);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'h80);
      send_byte(8'h00);
      settle();

      write_reg(CSR_IMAGE_LENGTH, 32'd0);
      send_byte(8'h81);
      send_byte(8'h10);
      settle();

      write_reg(CSR_IMAGE_LENGTH, 32'h7FFF);
      send_byte(8'h83);
      send_byte(8'h05);
      settle();
      // The length drops below the pixels already decoded.
      write_reg(CSR_IMAGE_LENGTH, 32'd2);
      send_byte(8'h00);
      send_byte(8'h07);

      phase_no = 0;
      while (sent < 230) begin
         settle();
         calm <= (phase_no == 2);
         hold_go <= (phase_no == 4);
         case ($urandom_range(3))
            0:       write_reg(CSR_PAL_OFFSET, 32'd0);
            1:       write_reg(CSR_PAL_OFFSET, 32'd255);
            default: write_reg(CSR_PAL_OFFSET, $urandom);
         endcase
         write_reg(CSR_SKIP_ZERO, $urandom);
         case ($urandom_range(9))
            0:       write_reg(CSR_IMAGE_LENGTH, 32'd0);
            1:       write_reg(CSR_IMAGE_LENGTH, 32'd1);
            2:       write_reg(CSR_IMAGE_LENGTH, 32'd32767);
            3:       write_reg(CSR_IMAGE_LENGTH, $urandom_range(2, 8));
            default: write_reg(CSR_IMAGE_LENGTH, $urandom_range(9, 300));
         endcase
         quota = sent + ((phase_no == 4) ? 60 : 40);
         while (sent < quota) begin
            case ($urandom_range(9))
               0: send_byte(8'($urandom_range(255)));
               1, 2, 3, 4: begin
                  send_byte({1'b1, run_bits()});
                  send_byte(pixel_byte());
               end
               default: begin
                  n = run_bits();
                  send_byte({1'b0, n});
                  for (i = 0; i <= n && sent < quota; i++) begin
                     send_byte(pixel_byte());
                  end
               end
            endcase
         end
         phase_no++;
      end
      settle();

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
